### rtl/core/tpca_pkg.sv
// shared widths, codes and state encoding for the terrain clearance angle core
`timescale 1ns / 1ps

package tpca_pkg;

  // serial multiplier: operand width and bits of the multiplier retired per cycle
  localparam int unsigned MUL_W     = 18;
  localparam int unsigned MUL_DIGIT = 2;

  // serial divider: dividend and divisor widths, quotient bits per cycle
  localparam int unsigned DIVD_W    = 36;
  localparam int unsigned DIVS_W    = 32;
  localparam int unsigned DIV_DIGIT = 2;

  // slopes are radians scaled by 2^SLOPE_SHIFT
  localparam int unsigned SLOPE_SHIFT = 20;

  // earth bulge x*(D-x)/k, k = 2 * 6371 km in metres
  localparam logic [23:0] BULGE_DIVISOR = 24'd12742000;

  typedef enum logic [1:0] {
    CFG_STEP   = 2'd0,
    CFG_PATH   = 2'd1,
    CFG_TX_ANT = 2'd2,
    CFG_RX_END = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MXW,
    S_BLG,
    S_MBW,
    S_DB,
    S_DBW,
    S_CORR,
    S_TX,
    S_TXW,
    S_TXU,
    S_RX,
    S_RXW,
    S_RXU,
    S_UPD,
    S_OUT
  } seq_state_e;

endpackage

### rtl/core/tpca_mul.sv
// unsigned shift-add multiplier, two multiplier bits per cycle
`timescale 1ns / 1ps

module tpca_mul
  import tpca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  output logic                 done_o,
  output logic [2*MUL_W-1:0]   prod_o
);

  localparam int unsigned STEPS = MUL_W / MUL_DIGIT;
  localparam int unsigned CW    = $clog2(STEPS);
  localparam int unsigned HW    = MUL_W + MUL_DIGIT + 1;

  logic [MUL_W-1:0]    a_q;
  logic [HW+MUL_W-1:0] acc_q;
  logic [HW+MUL_W-1:0] acc_d;
  logic [HW-1:0]       part;
  logic [CW-1:0]       cnt_q;
  logic                busy_q;
  logic                done_q;
  logic                last;

  // upper half plus a times the low digit, then shift the whole word right
  assign part  = acc_q[HW+MUL_W-1:MUL_W] + HW'(a_q) * HW'(acc_q[MUL_DIGIT-1:0]);
  assign acc_d = {{MUL_DIGIT{1'b0}}, part, acc_q[MUL_W-1:MUL_DIGIT]};
  assign last  = (cnt_q == CW'(STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{HW{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[2*MUL_W-1:0];

endmodule

### rtl/core/tpca_div.sv
// unsigned restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps

module tpca_div
  import tpca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);

  localparam int unsigned STEPS = DIVD_W / DIV_DIGIT;
  localparam int unsigned CW    = $clog2(STEPS);

  logic [DIVS_W-1:0] dsr_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_d;
  logic [DIVD_W-1:0] quo_d;
  logic [DIVS_W:0]   trial;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              last;

  // dividend bits shift out of the top of quo while quotient bits enter below
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial = {rem_d, quo_d[DIVD_W-1]};
      quo_d = {quo_d[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial    = trial - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DIVS_W-1:0];
    end
  end

  assign last = (cnt_q == CW'(STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/core/terrain_profile_clearance_angles_core.sv
// terrain profile clearance angle core: bulge, lowest point and steepest tx/rx slopes
// per sample: x multiply, bulge multiply and divide, tx and rx slope divides; a path start
// skips the slope divides, and the bulge or a slope is skipped near the path ends; the next
// input transfer can follow in the cycle after the result is loaded
// the shared divider (two quotient bits a cycle, three 18-step divisions) takes most of the time
// reset: config registers take their defaults, trackers clear, next sample starts a path
`timescale 1ns / 1ps

module terrain_profile_clearance_angles_core
  import tpca_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [14:0] terrain_height_i,
  input  logic               first_sample_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        bulge_o,
  output logic signed [14:0] corrected_height_o,
  output logic signed [31:0] tx_best_slope_o,
  output logic [15:0]        tx_best_index_o,
  output logic signed [14:0] tx_best_height_o,
  output logic signed [31:0] rx_best_slope_o,
  output logic [15:0]        rx_best_index_o,
  output logic signed [14:0] rx_best_height_o,
  output logic signed [14:0] lowest_height_o,
  output logic [15:0]        lowest_index_o
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);
  localparam logic signed [31:0] SLOPE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SLOPE_MAX = 32'sh7FFF_FFFF;

  // configuration registers
  logic [15:0]        step_q;
  logic [17:0]        path_q;
  logic [9:0]         tx_ant_q;
  logic signed [14:0] rx_end_q;

  // sequencer
  seq_state_e state_q, state_d;
  logic       mul_start, div_start;
  logic       mul_done, div_done;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_prod;
  logic [DIVD_W-1:0]  div_dividend, div_quot;
  logic [DIVS_W-1:0]  div_divisor;

  // per-sample working registers
  logic signed [14:0] h_q;
  logic               start_q;
  logic [IW-1:0]      idx_q;
  logic [31:0]        x_q;
  logic [10:0]        bulge_q;
  logic signed [14:0] corr_q;
  logic               neg_q;

  // path trackers
  logic [IW-1:0]      sample_index_q;
  logic signed [15:0] tx_ref_q;
  logic signed [31:0] tx_max_q;
  logic [IW-1:0]      tx_idx_q;
  logic signed [15:0] tx_hgt_q;
  logic signed [31:0] rx_max_q;
  logic [IW-1:0]      rx_idx_q;
  logic signed [14:0] rx_hgt_q;
  logic signed [14:0] min_hgt_q;
  logic [IW-1:0]      min_idx_q;

  // result register
  logic               out_valid_q;
  logic [10:0]        o_bulge_q;
  logic signed [14:0] o_corr_q;
  logic signed [31:0] o_tx_slope_q;
  logic [15:0]        o_tx_idx_q;
  logic signed [14:0] o_tx_hgt_q;
  logic signed [31:0] o_rx_slope_q;
  logic [15:0]        o_rx_idx_q;
  logic signed [14:0] o_rx_hgt_q;
  logic signed [14:0] o_min_hgt_q;
  logic [15:0]        o_min_idx_q;

  // combinational datapath
  logic               in_take;
  logic               in_start;
  logic [IW-1:0]      in_idx;
  logic               x_lt_d;
  logic [17:0]        d_minus_x;
  logic               tx_go, rx_go;
  logic signed [16:0] tx_dh, rx_dh, sel_dh;
  logic [15:0]        dh_mag;
  logic [10:0]        bulge_w;
  logic signed [15:0] corr_sum;
  logic signed [14:0] corr_w;
  logic signed [31:0] slope_w;
  logic signed [15:0] tx_ref_w;
  logic [IW-1:0]      idx_next;
  logic               out_free;

  // quotient magnitude and sign to saturated slope, truncated toward zero
  function automatic logic signed [31:0] sat_slope(input logic [DIVD_W-1:0] q,
                                                  input logic neg);
    logic big;
    big = |q[DIVD_W-1:31];
    if (neg) begin
      return big ? SLOPE_MIN : -$signed({1'b0, q[30:0]});
    end
    return big ? SLOPE_MAX : $signed({1'b0, q[30:0]});
  endfunction

  // configuration port; the user must write it only while the core is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= 16'd100;
      path_q   <= 18'd10000;
      tx_ant_q <= '0;
      rx_end_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_STEP:   step_q   <= cfg_data_i[15:0];
        CFG_PATH:   path_q   <= cfg_data_i;
        CFG_TX_ANT: tx_ant_q <= cfg_data_i[9:0];
        CFG_RX_END: rx_end_q <= $signed(cfg_data_i[14:0]);
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  // sample index zero only exists after reset, so it also opens a path
  assign in_start   = first_sample_i || (sample_index_q == '0);
  assign in_idx     = in_start ? '0 : sample_index_q;

  assign x_lt_d    = (x_q < 32'(path_q));
  assign d_minus_x = path_q - x_q[17:0];
  assign tx_go     = (x_q > 32'(step_q));
  assign rx_go     = x_lt_d && (d_minus_x > 18'(step_q));

  assign tx_dh  = 17'(corr_q) - 17'(tx_ref_q);
  assign rx_dh  = 17'(corr_q) - 17'(rx_end_q);
  assign sel_dh = (state_q == S_TX) ? tx_dh : rx_dh;
  assign dh_mag = sel_dh[16] ? 16'(-sel_dh) : 16'(sel_dh);

  // bulge from the divider, zero beyond the far end, clipped to eleven bits
  assign bulge_w  = !x_lt_d ? '0 :
                    (div_quot > DIVD_W'(2047)) ? 11'h7FF : div_quot[10:0];
  assign corr_sum = 16'(h_q) + $signed({5'b0, bulge_w});
  assign corr_w   = (corr_sum > 16'sd16383) ? 15'sh3FFF : corr_sum[14:0];

  assign slope_w  = sat_slope(div_quot, neg_q);
  assign tx_ref_w = 16'(h_q) + $signed({6'b0, tx_ant_q});
  assign idx_next = (idx_q == IDX_LAST) ? IDX_LAST : idx_q + IW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // unit operands: first multiply is index times step, second x times distance left
  assign mul_a = (state_q == S_IDLE) ? MUL_W'(in_idx) : x_q[MUL_W-1:0];
  assign mul_b = (state_q == S_IDLE) ? MUL_W'(step_q) : d_minus_x;

  assign div_dividend = (state_q == S_DB) ? mul_prod : {dh_mag, {SLOPE_SHIFT{1'b0}}};
  assign div_divisor  = (state_q == S_DB) ? DIVS_W'(BULGE_DIVISOR) :
                        (state_q == S_TX) ? x_q : DIVS_W'(d_minus_x);

  tpca_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  tpca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: one sample walks x, bulge, tx slope, rx slope, tracker update, result
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          mul_start = 1'b1;
          state_d   = S_MXW;
        end
      end
      S_MXW: begin
        if (mul_done) state_d = S_BLG;
      end
      S_BLG: begin
        // past the far end the bulge is zero, skip its multiply and divide
        if (x_lt_d) begin
          mul_start = 1'b1;
          state_d   = S_MBW;
        end else begin
          state_d = S_CORR;
        end
      end
      S_MBW: begin
        if (mul_done) state_d = S_DB;
      end
      S_DB: begin
        div_start = 1'b1;
        state_d   = S_DBW;
      end
      S_DBW: begin
        if (div_done) state_d = S_CORR;
      end
      S_CORR: state_d = S_TX;
      S_TX: begin
        if (!start_q && tx_go) begin
          div_start = 1'b1;
          state_d   = S_TXW;
        end else begin
          state_d = S_RX;
        end
      end
      S_TXW: begin
        if (div_done) state_d = S_TXU;
      end
      S_TXU: state_d = S_RX;
      S_RX: begin
        if (!start_q && rx_go) begin
          div_start = 1'b1;
          state_d   = S_RXW;
        end else begin
          state_d = S_UPD;
        end
      end
      S_RXW: begin
        if (div_done) state_d = S_RXU;
      end
      S_RXU: state_d = S_UPD;
      S_UPD: state_d = S_OUT;
      S_OUT: begin
        // wait here while the previous result is still held by the sink
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      h_q     <= terrain_height_i;
      start_q <= in_start;
      idx_q   <= in_idx;
    end
    if (state_q == S_MXW && mul_done) begin
      x_q <= mul_prod[31:0];
    end
    if (state_q == S_CORR) begin
      bulge_q <= bulge_w;
      corr_q  <= corr_w;
    end
    if ((state_q == S_TX || state_q == S_RX) && div_start) begin
      neg_q <= sel_dh[16];
    end
  end

  // path trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      tx_ref_q       <= '0;
      tx_max_q       <= SLOPE_MIN;
      tx_idx_q       <= '0;
      tx_hgt_q       <= '0;
      rx_max_q       <= SLOPE_MIN;
      rx_idx_q       <= '0;
      rx_hgt_q       <= '0;
      min_hgt_q      <= '0;
      min_idx_q      <= '0;
    end else begin
      // only a strictly steeper slope replaces the kept one
      if (state_q == S_TXU && slope_w > tx_max_q) begin
        tx_max_q <= slope_w;
        tx_idx_q <= idx_q;
        tx_hgt_q <= 16'(corr_q);
      end
      if (state_q == S_RXU && slope_w > rx_max_q) begin
        rx_max_q <= slope_w;
        rx_idx_q <= idx_q;
        rx_hgt_q <= corr_q;
      end
      if (state_q == S_UPD) begin
        sample_index_q <= idx_next;
        if (start_q) begin
          tx_ref_q  <= tx_ref_w;
          tx_max_q  <= SLOPE_MIN;
          tx_idx_q  <= '0;
          tx_hgt_q  <= tx_ref_w;
          rx_max_q  <= SLOPE_MIN;
          rx_idx_q  <= '0;
          rx_hgt_q  <= rx_end_q;
          min_hgt_q <= h_q;
          min_idx_q <= '0;
        end else if (h_q < min_hgt_q) begin
          min_hgt_q <= h_q;
          min_idx_q <= idx_q;
        end
      end
    end
  end

  // result register, parts the sink from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      o_bulge_q    <= bulge_q;
      o_corr_q     <= corr_q;
      o_tx_slope_q <= tx_max_q;
      o_tx_idx_q   <= 16'(tx_idx_q);
      o_tx_hgt_q   <= tx_hgt_q[14:0];
      o_rx_slope_q <= rx_max_q;
      o_rx_idx_q   <= 16'(rx_idx_q);
      o_rx_hgt_q   <= rx_hgt_q;
      o_min_hgt_q  <= min_hgt_q;
      o_min_idx_q  <= 16'(min_idx_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign bulge_o            = o_bulge_q;
  assign corrected_height_o = o_corr_q;
  assign tx_best_slope_o    = o_tx_slope_q;
  assign tx_best_index_o    = o_tx_idx_q;
  assign tx_best_height_o   = o_tx_hgt_q;
  assign rx_best_slope_o    = o_rx_slope_q;
  assign rx_best_index_o    = o_rx_idx_q;
  assign rx_best_height_o   = o_rx_hgt_q;
  assign lowest_height_o    = o_min_hgt_q;
  assign lowest_index_o     = o_min_idx_q;

  // unit completions only arrive while the sequencer waits on them
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MXW || state_q == S_MBW))
    else $error("multiplier finished outside a multiply wait");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DBW || state_q == S_TXW || state_q == S_RXW))
    else $error("divider finished outside a divide wait");

  // a held result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> (state_q == S_OUT))
    else $error("result loaded while previous one still stalled");

  // the sample index saturates and never wraps back to zero
  a_idx_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (sample_index_q != '0))
    else $error("sample index wrapped to zero");

endmodule
